[design/ili_pkg.sv]
`default_nettype none
package ili_pkg;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned IdxW  = 7;
  localparam int unsigned WordW = 32;
  localparam int unsigned StW   = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_READ   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_ERASE  = 3'd2,
    CMD_PUSH   = 3'd3,
    CMD_POP    = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_RESIZE = 3'd6,
    CMD_ASSIGN = 3'd7
  } cmd_e;

  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PLAN_NONE = 3'd0,
    PLAN_READ = 3'd1,
    PLAN_UP   = 3'd2,
    PLAN_DOWN = 3'd3,
    PLAN_FILL = 3'd4
  } plan_e;

  typedef struct packed {
    logic [CmdW-1:0]         cmd;
    logic [IdxW-1:0]         position;
    logic signed [WordW-1:0] word_in;
    logic [IdxW-1:0]         new_length;
  } in_t;

  typedef struct packed {
    logic signed [WordW-1:0] word_out;
    logic [StW-1:0]          status;
    logic [IdxW-1:0]         length;
  } out_t;

  typedef struct packed {
    logic cap;
    logic eval;
    logic walk;
    logic put;
    logic fin;
  } ctl_t;

  typedef struct packed {
    plan_e plan;
    logic  up;
    logic  last;
  } sts_t;

endpackage
`default_nettype wire

[design/ili_ctrl.sv]
`default_nettype none
module ili_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  ili_pkg::sts_t      sts_i,
  output ili_pkg::ctl_t      ctl_o
);
  import ili_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_WALK = 5'b00100,
    S_PUT  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.cap = 1'b1;
          state_d   = S_EVAL;
        end
      end
      S_EVAL: begin
        ctl_o.eval = 1'b1;
        if (sts_i.plan == PLAN_UP || sts_i.plan == PLAN_DOWN || sts_i.plan == PLAN_FILL) begin
          state_d = S_WALK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WALK: begin
        ctl_o.walk = 1'b1;
        if (sts_i.last) begin
          state_d = sts_i.up ? S_PUT : S_DONE;
        end
      end
      S_PUT: begin
        ctl_o.put = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        ctl_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

[design/ili_dp.sv]
`default_nettype none
module ili_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  ili_pkg::ctl_t      ctl_i,
  input  ili_pkg::in_t       item_i,
  output ili_pkg::sts_t      sts_o,
  output logic               done_o,
  output ili_pkg::out_t      result_o
);
  import ili_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > IdxW) ? CW : IdxW;
  localparam logic [PW-1:0] DepthP = PW'(DEPTH);

  logic signed [WordW-1:0] mem [DEPTH];

  cmd_e                    cmd_q;
  logic [PW-1:0]           pos_q;
  logic signed [WordW-1:0] word_q;
  logic [PW-1:0]           nl_q;
  logic [CW-1:0]           count_q;
  logic [PW-1:0]           ptr_q;
  plan_e                   plan_q;
  status_e                 st_q;
  logic signed [WordW-1:0] rdata_q;
  logic                    pend_q;
  logic [AW-1:0]           wa_q;
  out_t                    res_q;
  logic                    done_q;

  logic [PW-1:0]           count_p;
  logic [PW-1:0]           ptr_m1;
  plan_e                   plan_c;
  status_e                 st_c;
  logic                    more;
  logic                    full;
  logic                    empty;
  logic [AW-1:0]           raddr;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic signed [WordW-1:0] wdata;

  assign count_p = PW'(count_q);
  assign ptr_m1  = ptr_q - 1'b1;
  assign full    = (count_p == DepthP);
  assign empty   = (count_q == '0);

  always_comb begin
    plan_c = PLAN_NONE;
    st_c   = ST_OK;
    unique case (cmd_q)
      CMD_READ: begin
        if (pos_q >= count_p) begin
          st_c = ST_RANGE;
        end else begin
          plan_c = PLAN_READ;
        end
      end
      CMD_INSERT: begin
        if (pos_q > count_p) begin
          st_c = ST_RANGE;
        end else if (full) begin
          st_c = ST_FULL;
        end else begin
          plan_c = PLAN_UP;
        end
      end
      CMD_ERASE: begin
        if (empty) begin
          st_c = ST_EMPTY;
        end else if (pos_q >= count_p) begin
          st_c = ST_RANGE;
        end else begin
          plan_c = PLAN_DOWN;
        end
      end
      CMD_PUSH: begin
        if (full) begin
          st_c = ST_FULL;
        end else begin
          plan_c = PLAN_UP;
        end
      end
      CMD_POP: begin
        if (empty) begin
          st_c = ST_EMPTY;
        end
      end
      CMD_CLEAR: begin
        st_c = ST_OK;
      end
      CMD_RESIZE: begin
        if (nl_q > DepthP) begin
          st_c = ST_FULL;
        end else if (nl_q > count_p) begin
          plan_c = PLAN_FILL;
        end
      end
      CMD_ASSIGN: begin
        if (nl_q > DepthP) begin
          st_c = ST_FULL;
        end else begin
          plan_c = PLAN_FILL;
        end
      end
    endcase
  end

  always_comb begin
    case (plan_q)
      PLAN_UP:   more = (ptr_q > pos_q);
      PLAN_DOWN: more = (ptr_q < count_p);
      PLAN_FILL: more = (ptr_q < nl_q);
      default:   more = 1'b0;
    endcase
  end

  always_comb begin
    raddr = pos_q[AW-1:0];
    if (ctl_i.walk && plan_q == PLAN_UP) begin
      raddr = ptr_m1[AW-1:0];
    end else if (ctl_i.walk && plan_q == PLAN_DOWN) begin
      raddr = ptr_q[AW-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = wa_q;
    wdata = rdata_q;
    if (pend_q) begin
      we = 1'b1;
    end else if (ctl_i.walk && plan_q == PLAN_FILL && more) begin
      we    = 1'b1;
      waddr = ptr_q[AW-1:0];
      wdata = word_q;
    end else if (ctl_i.put) begin
      we    = 1'b1;
      waddr = pos_q[AW-1:0];
      wdata = word_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= ctl_i.fin;
      pend_q <= ctl_i.walk && more && (plan_q == PLAN_UP || plan_q == PLAN_DOWN);
      if (ctl_i.eval && st_c == ST_OK) begin
        case (cmd_q)
          CMD_POP:    count_q <= count_q - 1'b1;
          CMD_CLEAR:  count_q <= '0;
          CMD_RESIZE: begin
            if (plan_c == PLAN_NONE) begin
              count_q <= CW'(nl_q);
            end
          end
          default:    count_q <= count_q;
        endcase
      end
      if (ctl_i.walk && !more) begin
        if (plan_q == PLAN_DOWN) begin
          count_q <= count_q - 1'b1;
        end else if (plan_q == PLAN_FILL) begin
          count_q <= CW'(nl_q);
        end
      end
      if (ctl_i.put) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      cmd_q  <= cmd_e'(item_i.cmd);
      pos_q  <= (cmd_e'(item_i.cmd) == CMD_PUSH) ? count_p : PW'(item_i.position);
      word_q <= item_i.word_in;
      nl_q   <= PW'(item_i.new_length);
    end
    if (ctl_i.eval) begin
      plan_q <= plan_c;
      st_q   <= st_c;
      case (plan_c)
        PLAN_UP:   ptr_q <= count_p;
        PLAN_DOWN: ptr_q <= PW'(pos_q + 1'b1);
        PLAN_FILL: ptr_q <= (cmd_q == CMD_ASSIGN) ? '0 : count_p;
        default:   ptr_q <= ptr_q;
      endcase
    end
    if (ctl_i.walk && more) begin
      if (plan_q == PLAN_UP) begin
        ptr_q <= ptr_m1;
        wa_q  <= ptr_q[AW-1:0];
      end else begin
        ptr_q <= PW'(ptr_q + 1'b1);
        wa_q  <= ptr_m1[AW-1:0];
      end
    end
    if (ctl_i.fin) begin
      res_q.word_out <= (plan_q == PLAN_READ) ? rdata_q : '0;
      res_q.status   <= st_q;
      res_q.length   <= IdxW'(count_q);
    end
  end

  assign sts_o.plan = plan_c;
  assign sts_o.up   = (plan_q == PLAN_UP);
  assign sts_o.last = !more;

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

[design/indexed_list_insert_erase.sv]
// Read, pop, clear, truncating resize and every failed command go from capture through
// evaluation to the done state and the registered result strobe; insert and push add a
// shift walk and a write of the new entry, erase a shift walk, and a fill a walk over the
// slots filled. One item is in flight at a time, so a new item is taken only after the last;
// shifts and fills move one entry per cycle. The receiver cannot stall the result.
// Reset clears the length and the controller; the entry memory is not cleared.
`default_nettype none
module indexed_list_insert_erase #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  ili_pkg::in_t       item_i,
  output logic               done_o,
  output ili_pkg::out_t      result_o
);
  import ili_pkg::*;

  ctl_t ctl;
  sts_t sts;

  ili_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  ili_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .item_i   (item_i),
    .sts_o    (sts),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
module tb;
  import ili_pkg::*;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned MAX_SHOWN  = 10;

  typedef struct packed {
    in_t  item;
    logic drain;
  } stim_t;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start  = 1'b0;
  in_t   item_i = '0;
  logic  busy;
  logic  done_o;
  out_t  result_o;

  stim_t       stim_q[$];
  out_t        expect_q[$];
  logic [31:0] list_mem[DEPTH];
  int unsigned list_len = 0;
  logic        took = 1'b0;
  int          gap_left = 0;
  int          calm_left = 0;
  int          idle_cycles = 0;
  int          errors = 0;

  indexed_list_insert_erase #(.DEPTH(DEPTH)) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic out_t list_apply(in_t it);
    out_t        r;
    int unsigned p;
    int unsigned nl;
    int unsigned i;
    r = '0;
    r.status = ST_OK;
    p = it.position;
    nl = it.new_length;
    case (cmd_e'(it.cmd))
      CMD_READ: begin
        if (p >= list_len) r.status = ST_RANGE;
        else r.word_out = list_mem[p];
      end
      CMD_INSERT: begin
        if (p > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = it.word_in;
          list_len++;
        end
      end
      CMD_ERASE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = p + 1; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
        end
      end
      CMD_PUSH: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = it.word_in;
          list_len++;
        end
      end
      CMD_POP: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else list_len--;
      end
      CMD_CLEAR: list_len = 0;
      CMD_RESIZE: begin
        if (nl > DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i < nl; i++) list_mem[i] = it.word_in;
          list_len = nl;
        end
      end
      default: begin
        if (nl > DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = 0; i < nl; i++) list_mem[i] = it.word_in;
          list_len = nl;
        end
      end
    endcase
    r.length = 7'(list_len);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic queue_item(cmd_e c, int unsigned pos, logic [31:0] w, int unsigned nl,
                            logic drain);
    stim_t s;
    s.item.cmd        = c;
    s.item.position   = 7'(pos);
    s.item.word_in    = w;
    s.item.new_length = 7'(nl);
    s.drain           = drain;
    stim_q.insert(stim_q.size(), s);
  endtask

  task automatic report(string what);
    errors++;
    if (errors <= MAX_SHOWN) $display("%0t: %s", $time, what);
  endtask

  always @(negedge clk_i) begin : drive
    stim_t nxt;
    if (rst_ni && !(start && !took)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (stim_q.size() > 0 && !(stim_q[0].drain && expect_q.size() > 0)) begin
        nxt = stim_q.pop_front();
        item_i <= nxt.item;
        start <= 1'b1;
        gap_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch
    out_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expect_q.size() == 0) begin
          report($sformatf("unexpected result: word %h status %0d length %0d",
                           result_o.word_out, result_o.status, result_o.length));
        end else begin
          want = expect_q.pop_front();
          if (result_o.word_out !== want.word_out || result_o.status !== want.status ||
              result_o.length !== want.length) begin
            report($sformatf({"mismatch: expected word %h status %0d length %0d, ",
                              "got word %h status %0d length %0d"},
                             want.word_out, want.status, want.length,
                             result_o.word_out, result_o.status, result_o.length));
          end
        end
      end
      if (start && !busy) expect_q.insert(expect_q.size(), list_apply(item_i));
      took <= start && !busy;
      if (done_o || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : run
    int   n;
    int   r;
    int   est_len;
    int   pos;
    int   nl;
    cmd_e c;
    logic grow;

    queue_item(CMD_READ,   0,  32'h0,        0,   1'b0);
    queue_item(CMD_POP,    0,  32'h0,        0,   1'b0);
    queue_item(CMD_ERASE,  0,  32'h0,        0,   1'b0);
    queue_item(CMD_INSERT, 1,  32'h1234_5678, 0,  1'b0);
    queue_item(CMD_INSERT, 0,  32'h7fff_ffff, 0,  1'b0);
    queue_item(CMD_PUSH,   0,  32'h8000_0000, 0,  1'b0);
    queue_item(CMD_INSERT, 1,  32'hffff_ffff, 0,  1'b0);
    queue_item(CMD_INSERT, 3,  32'h0,        0,   1'b0);
    for (n = 0; n < 5; n++) queue_item(CMD_READ, n, 32'h0, 0, 1'b0);
    queue_item(CMD_ERASE,  4,  32'h0,        0,   1'b0);
    queue_item(CMD_ERASE,  1,  32'h0,        0,   1'b0);
    queue_item(CMD_RESIZE, 0,  32'h5555_aaaa, 10, 1'b0);
    queue_item(CMD_RESIZE, 0,  32'h0,        10,  1'b0);
    queue_item(CMD_RESIZE, 0,  32'h0,        2,   1'b0);
    queue_item(CMD_RESIZE, 0,  32'h0,        65,  1'b0);
    queue_item(CMD_ASSIGN, 0,  32'h0,        127, 1'b0);
    queue_item(CMD_ASSIGN, 0,  32'ha5a5_a5a5, 64, 1'b0);
    queue_item(CMD_PUSH,   0,  32'h1,        0,   1'b0);
    queue_item(CMD_INSERT, 64, 32'h2,        0,   1'b0);
    queue_item(CMD_INSERT, 65, 32'h3,        0,   1'b0);
    queue_item(CMD_ERASE,  0,  32'h0,        0,   1'b0);
    queue_item(CMD_READ,   127, 32'h0,       0,   1'b0);
    queue_item(CMD_CLEAR,  0,  32'h0,        0,   1'b0);
    queue_item(CMD_ASSIGN, 0,  32'h0,        0,   1'b0);

    est_len = 0;
    grow = 1'b1;
    for (n = 0; n < 650; n++) begin
      if (n % 60 == 0) grow = (est_len < 40);
      r = $urandom_range(0, 99);
      if (grow) begin
        c = cmd_e'(r < 25 ? CMD_INSERT : r < 50 ? CMD_PUSH : r < 75 ? CMD_READ :
                   r < 83 ? CMD_ERASE : r < 88 ? CMD_POP : r < 93 ? CMD_RESIZE :
                   r < 97 ? CMD_ASSIGN : CMD_CLEAR);
      end else begin
        c = cmd_e'(r < 12 ? CMD_INSERT : r < 20 ? CMD_PUSH : r < 48 ? CMD_READ :
                   r < 74 ? CMD_ERASE : r < 88 ? CMD_POP : r < 94 ? CMD_RESIZE :
                   r < 97 ? CMD_ASSIGN : CMD_CLEAR);
      end
      pos = ($urandom_range(0, 99) < 88) ? $urandom_range(0, est_len) : $urandom_range(0, 127);
      nl = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 64) : $urandom_range(65, 127);
      queue_item(c, pos, $urandom, nl, n == 0 || n == 325);
      case (c)
        CMD_READ:   ;
        CMD_INSERT: if (pos <= est_len && est_len < 64) est_len++;
        CMD_PUSH:   if (est_len < 64) est_len++;
        CMD_ERASE:  if (pos < est_len) est_len--;
        CMD_POP:    if (est_len > 0) est_len--;
        CMD_CLEAR:  est_len = 0;
        default:    if (nl <= 64) est_len = nl;
      endcase
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (!(stim_q.size() == 0 && !start && expect_q.size() == 0)) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    errors += expect_q.size();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
